// ===== hdl/mqts_pkg.sv =====
// Shared types, constants and helpers for the two-stack max queue.
// Used by the channel interfaces, the controller, the datapath and the top level.
package mqts_pkg;

  // Store geometry
  localparam int QUEUE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int DATA_W      = 32;
  localparam int ENTRY_W     = 2 * DATA_W;

  // Operation codes
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_ENQ   = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // Result status codes
  localparam int ST_W = 2;
  localparam logic [ST_W-1:0] STAT_OK    = 2'd0;
  localparam logic [ST_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [ST_W-1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_XFER_RD,
    S_XFER_WR,
    S_POP,
    S_POP_LOAD,
    S_RESP
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic            start;     // new item taken: clear dequeued value (or take front top on a pop), set status
    logic [ST_W-1:0] stat_code;
    logic            push;      // push request value onto back stack
    logic            pop;       // pop cached front top, fetch the next one
    logic            pop_load;  // load fetched entry as front top
    logic            xfer_rd;   // read back top, shrink back stack
    logic            xfer_wr;   // push read entry onto front stack
    logic            load_out;  // capture result into output register
  } ctl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic front_empty;
    logic front_more;   // more than one entry on front stack
    logic back_empty;
    logic out_free;     // output register can take a result this cycle
  } dp_stat_t;

  // Signed maximum of two words
  function automatic logic signed [DATA_W-1:0] smax(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== hdl/mqts_ifs.sv =====
// Valid/ready channel interfaces for requests and results of the max queue.
// Depends on mqts_pkg for field widths.
interface mqts_req_if import mqts_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, op, value, input ready);
  modport sink (input valid, op, value, output ready);
endinterface

interface mqts_rsp_if import mqts_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] dequeued_value;
  logic signed [DATA_W-1:0] max_value;
  logic                     is_empty;
  logic [ST_W-1:0]          status;

  modport source (output valid, dequeued_value, max_value, is_empty, status, input ready);
  modport sink (input valid, dequeued_value, max_value, is_empty, status, output ready);
endinterface

// ===== hdl/mqts_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package dependency.
module mqts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/mqts_ctrl.sv =====
// Sequencer for the two-stack max queue: accepts items and steps the datapath.
// Depends on mqts_pkg for state, command and status types.
module mqts_ctrl import mqts_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic [OP_W-1:0] req_op,
  output logic            req_ready,
  input  dp_stat_t        stat,
  output ctl_cmd_t        cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          unique case (req_op)
            OP_DEQ: begin
              if (stat.empty) begin
                state_next = S_RESP;
              end else if (stat.front_empty) begin
                state_next = S_XFER_RD;
              end else if (stat.front_more) begin
                state_next = S_POP_LOAD;
              end else begin
                state_next = S_RESP;
              end
            end
            default: state_next = S_RESP;
          endcase
        end
      end
      S_XFER_RD: state_next = S_XFER_WR;
      S_XFER_WR: state_next = stat.back_empty ? S_POP : S_XFER_RD;
      S_POP:     state_next = stat.front_more ? S_POP_LOAD : S_RESP;
      S_POP_LOAD: state_next = S_RESP;
      S_RESP: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.start     = 1'b1;
          cmd.stat_code = STAT_OK;
          unique case (req_op)
            OP_ENQ: begin
              if (stat.full) begin
                cmd.stat_code = STAT_FULL;
              end else begin
                cmd.push = 1'b1;
              end
            end
            OP_DEQ: begin
              if (stat.empty) begin
                cmd.stat_code = STAT_EMPTY;
              end else if (!stat.front_empty) begin
                cmd.pop = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_XFER_RD:  cmd.xfer_rd  = 1'b1;
      S_XFER_WR:  cmd.xfer_wr  = 1'b1;
      S_POP:      cmd.pop      = 1'b1;
      S_POP_LOAD: cmd.pop_load = 1'b1;
      S_RESP:     cmd.load_out = stat.out_free;
      default: ;
    endcase
  end

endmodule

// ===== hdl/mqts_dp.sv =====
// Datapath of the two-stack max queue: stack pointers, cached tops, entry RAM, result register.
// Depends on mqts_pkg, mqts_ifs (result channel) and mqts_ram.
module mqts_dp import mqts_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic signed [DATA_W-1:0] req_value,
  input  ctl_cmd_t                 cmd,
  output dp_stat_t                 stat,
  mqts_rsp_if.source               rsp
);

  logic [CNT_W-1:0]         back_count;
  logic [CNT_W-1:0]         front_count;
  logic signed [DATA_W-1:0] back_max;
  logic signed [DATA_W-1:0] ftop_val;
  logic signed [DATA_W-1:0] ftop_max;
  logic signed [DATA_W-1:0] deq_val;
  logic [ST_W-1:0]          stat_code;
  logic                     out_valid;

  logic [CNT_W:0]           total;
  logic signed [DATA_W-1:0] push_max;
  logic signed [DATA_W-1:0] rd_val;
  logic signed [DATA_W-1:0] xfer_max;
  logic signed [DATA_W-1:0] cur_max;
  logic [CNT_W-1:0]         back_rd_ptr;
  logic [CNT_W-1:0]         front_rd_ptr;
  logic [CNT_W-1:0]         front_wr_ptr;
  logic                     ram_wen;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [ENTRY_W-1:0]       ram_wdata;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [ENTRY_W-1:0]       ram_rdata;

  // Occupancy flags
  assign total = {1'b0, back_count} + {1'b0, front_count};
  always_comb begin
    stat.full        = (total == (CNT_W+1)'(QUEUE_DEPTH));
    stat.empty       = (total == '0);
    stat.front_empty = (front_count == '0);
    stat.front_more  = (front_count > CNT_W'(1));
    stat.back_empty  = (back_count == '0);
    stat.out_free    = !out_valid || rsp.ready;
  end

  // Running maxima for the back push and the front push
  assign push_max = (back_count != '0) ? smax(back_max, req_value) : req_value;
  assign rd_val   = ram_rdata[ENTRY_W-1:DATA_W];
  assign xfer_max = (front_count != '0) ? smax(ftop_max, rd_val) : rd_val;

  // Store addresses: back grows up from 0, front grows down from the last entry
  assign back_rd_ptr  = back_count - CNT_W'(1);
  assign front_rd_ptr = CNT_W'(QUEUE_DEPTH + 1) - front_count;
  assign front_wr_ptr = CNT_W'(QUEUE_DEPTH - 1) - front_count;

  always_comb begin
    ram_wen   = cmd.push || cmd.xfer_wr;
    ram_waddr = cmd.xfer_wr ? front_wr_ptr[ADDR_W-1:0] : back_count[ADDR_W-1:0];
    ram_wdata = cmd.xfer_wr ? {rd_val, xfer_max} : {req_value, push_max};
    ram_raddr = cmd.xfer_rd ? back_rd_ptr[ADDR_W-1:0] : front_rd_ptr[ADDR_W-1:0];
  end

  mqts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .wen   (ram_wen),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Stack pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      back_count  <= '0;
      front_count <= '0;
    end else begin
      if (cmd.push) begin
        back_count <= back_count + CNT_W'(1);
      end else if (cmd.xfer_rd) begin
        back_count <= back_rd_ptr;
      end
      if (cmd.xfer_wr) begin
        front_count <= front_count + CNT_W'(1);
      end else if (cmd.pop) begin
        front_count <= front_count - CNT_W'(1);
      end
    end
  end

  // Cached stack tops and per-item result fields
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      back_max <= push_max;
    end
    if (cmd.xfer_wr) begin
      ftop_val <= rd_val;
      ftop_max <= xfer_max;
    end else if (cmd.pop_load) begin
      ftop_val <= rd_val;
      ftop_max <= ram_rdata[DATA_W-1:0];
    end
    if (cmd.start) begin
      deq_val   <= cmd.pop ? ftop_val : '0;
      stat_code <= cmd.stat_code;
    end else if (cmd.pop) begin
      deq_val <= ftop_val;
    end
  end

  // Maximum over both stack tops
  always_comb begin
    priority if (back_count != '0 && front_count != '0) begin
      cur_max = smax(back_max, ftop_max);
    end else if (back_count != '0) begin
      cur_max = back_max;
    end else if (front_count != '0) begin
      cur_max = ftop_max;
    end else begin
      cur_max = '0;
    end
  end

  // Output register: hold until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp.dequeued_value <= deq_val;
      rsp.max_value      <= cur_max;
      rsp.is_empty       <= stat.empty;
      rsp.status         <= stat_code;
    end
  end

  assign rsp.valid = out_valid;

endmodule

// ===== hdl/max_queue_two_stacks.sv =====
// FIFO of signed 32-bit integers that reports its current maximum, built as two stacks in one
// RAM of QUEUE_DEPTH entries, each entry holding a value and its stack's running maximum.
// Items are taken one at a time. Enqueue, query and any rejected operation are accepted, then
// their result goes into the output register. A dequeue with a non-empty front stack pops at
// accept, fetches a further front entry from the RAM if one remains, then loads its result. A
// dequeue that finds the front stack empty at accept first moves the whole back stack across,
// each entry by a RAM read, then a write of the new front entry with its recomputed maximum,
// then pops, fetches a further front entry if one remains, and loads its result.
// The result register frees the input side: a pending result waits there while the
// next item is accepted. No clearing pass is needed after reset.
// Depends on mqts_pkg, mqts_ifs, mqts_ctrl and mqts_dp.
module max_queue_two_stacks import mqts_pkg::*; (
  input logic        clk,
  input logic        rst,
  mqts_req_if.sink   req,
  mqts_rsp_if.source rsp
);

  ctl_cmd_t cmd;
  dp_stat_t stat;
  logic     ready;

  assign req.ready = ready;

  mqts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.op),
    .req_ready (ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mqts_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_value (req.value),
    .cmd       (cmd),
    .stat      (stat),
    .rsp       (rsp)
  );

endmodule
